// File: rtl/core/lru_key_value_cache_top_assert.svh
// Assertion macros for the cache RTL.
// They expect clk and rst_n in scope.
`ifndef LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define LKV_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define LKV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/lkv_pkg.sv
`default_nettype none

package lkv_pkg;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 31;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Passed from cell i+1 down to cell i: match seen further along, and its value.
  typedef struct packed {
    logic               seen;
    logic [VALUE_W-1:0] value;
  } lkv_tail_t;

  // Update controls broadcast to every cell.
  typedef struct packed {
    logic upd;  // update cycle
    logic ins;  // put of an absent key
  } lkv_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/lkv_cell.sv
`default_nettype none

module lkv_cell import lkv_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  wire logic               clk,
  input  wire logic               accept,
  input  wire logic [KEY_W-1:0]   cmp_key,
  input  wire lkv_ctl_t           ctl,
  input  wire logic [CW-1:0]      occ,
  input  wire logic [CW-1:0]      ins_pos,
  input  wire logic [KEY_W-1:0]   prev_key,
  input  wire logic [VALUE_W-1:0] prev_value,
  input  wire lkv_tail_t          tail_in,
  output logic [KEY_W-1:0]        key,
  output logic [VALUE_W-1:0]      value,
  output lkv_tail_t               tail_out,
  output logic                    match
);

  logic [KEY_W-1:0]   key_r;
  logic [VALUE_W-1:0] value_r;
  logic               match_r;
  logic               valid;
  logic               ins_here;
  logic               shift_en;

  assign valid    = CW'(IDX) < occ;
  assign ins_here = ctl.ins && (CW'(IDX) <= ins_pos);
  // Cells from the front up to the hit (or insert point) take the neighbour's entry.
  assign shift_en = ctl.upd && (match_r || tail_in.seen || ins_here);

  always_ff @(posedge clk) begin
    if (accept) begin
      match_r <= valid && (key_r == cmp_key);
    end
    if (shift_en) begin
      key_r   <= prev_key;
      value_r <= prev_value;
    end
  end

  assign key            = key_r;
  assign value          = value_r;
  assign match          = match_r;
  assign tail_out.seen  = tail_in.seen | match_r;
  assign tail_out.value = tail_in.value | (match_r ? value_r : '0);

endmodule

`default_nettype wire

// File: rtl/core/lru_key_value_cache_top.sv
`default_nettype none
// Channel   | Ports                                         | Handshake
// ----------+-----------------------------------------------+---------------------------
// input     | in_cmd, in_key, in_value                      | start & !busy
// result    | out_hit, out_value_out, out_evicted           | out_valid, one-cycle strobe
// config    | cfg_capacity_in_use                           | cfg_valid & cfg_ready
//
// On the accept edge every cell registers its key match at once, the following
// update cycle shifts the recency chain and the result word appears on the cycle
// after that. busy is high during the update cycle.
// A new word may be accepted while the previous result strobe is showing.
// Synchronous active-low reset empties the store and sets capacity to 16.
// The receiver cannot stall; out_valid lasts exactly one cycle.
`include "lru_key_value_cache_top_assert.svh"

module lru_key_value_cache_top import lkv_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                in_cmd,
  input  wire logic signed [31:0]  in_key,
  input  wire logic [VALUE_W-1:0]  in_value,
  output logic                     out_valid,
  output logic                     out_hit,
  output logic [VALUE_W-1:0]       out_value_out,
  output logic                     out_evicted,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CAP_W-1:0]    cfg_capacity_in_use
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic               state_r, state_nxt;
  logic [CAP_W-1:0]   cap_r;
  logic [CW-1:0]      occ_r;
  logic               op_cmd_r;
  logic [KEY_W-1:0]   op_key_r;
  logic [VALUE_W-1:0] op_value_r;

  logic               out_valid_r;
  logic               out_hit_r;
  logic [VALUE_W-1:0] out_value_r;
  logic               out_evicted_r;

  logic               accept;
  logic [EW-1:0]      cap_ext;
  logic [EW-1:0]      cap_eff_w;
  logic [CW-1:0]      cap_eff;
  logic               full;
  logic [CW-1:0]      ins_pos;
  logic               hit_c;
  logic               evict_c;
  lkv_ctl_t           ctl;

  logic [KEY_W-1:0]   cell_key   [ENTRIES];
  logic [VALUE_W-1:0] cell_value [ENTRIES];
  lkv_tail_t          tail       [ENTRIES+1];
  logic [ENTRIES-1:0] match_vec;
  logic [VALUE_W-1:0] front_value;

  assign accept    = start && !busy;
  assign busy      = (state_r == ST_UPD);
  assign cfg_ready = 1'b1;

  // Capacity of zero acts as one; anything above the store size is clipped.
  assign cap_ext = EW'(cap_r);
  always_comb begin
    priority if (cap_ext == '0) begin
      cap_eff_w = EW'(1);
    end else if (cap_ext > EW'(ENTRIES)) begin
      cap_eff_w = EW'(ENTRIES);
    end else begin
      cap_eff_w = cap_ext;
    end
  end
  assign cap_eff = cap_eff_w[CW-1:0];

  // Full (or over a lowered capacity): the new word lands at cap-1 and the tail drops off.
  assign full    = occ_r >= cap_eff;
  assign ins_pos = full ? (cap_eff - CW'(1)) : occ_r;

  assign hit_c    = tail[0].seen;
  assign ctl.upd  = (state_r == ST_UPD);
  assign ctl.ins  = (op_cmd_r == CMD_PUT) && !hit_c;
  assign evict_c  = ctl.ins && full;

  // Front of the chain: a get hit re-inserts its own value, a put brings the new one.
  assign front_value = (op_cmd_r == CMD_PUT) ? op_value_r : tail[0].value;

  assign tail[ENTRIES] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [KEY_W-1:0]   prev_key;
    logic [VALUE_W-1:0] prev_value;

    if (i == 0) begin : g_front
      assign prev_key   = op_key_r;
      assign prev_value = front_value;
    end else begin : g_link
      assign prev_key   = cell_key[i-1];
      assign prev_value = cell_value[i-1];
    end

    lkv_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .accept     (accept),
      .cmp_key    (in_key),
      .ctl        (ctl),
      .occ        (occ_r),
      .ins_pos    (ins_pos),
      .prev_key   (prev_key),
      .prev_value (prev_value),
      .tail_in    (tail[i+1]),
      .key        (cell_key[i]),
      .value      (cell_value[i]),
      .tail_out   (tail[i]),
      .match      (match_vec[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= ctl.upd;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity_in_use;
      end
      if (ctl.upd && ctl.ins) begin
        occ_r <= ins_pos + CW'(1);
      end
    end
  end

  // Operation and result words: no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_cmd_r   <= in_cmd;
      op_key_r   <= in_key;
      op_value_r <= in_value;
    end
    if (ctl.upd) begin
      out_hit_r     <= hit_c;
      out_value_r   <= (op_cmd_r == CMD_GET && hit_c) ? tail[0].value : '0;
      out_evicted_r <= evict_c;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_value_out = out_value_r;
  assign out_evicted   = out_evicted_r;

  // Keys are unique in the store, so at most one cell matches.
  `LKV_ASSERT_SAME(a_single_match, busy, $onehot0(match_vec), "more than one cell matched")
  `LKV_ASSERT_SAME(a_occ_bound, 1'b1, occ_r <= CW'(ENTRIES), "occupancy above store size")
  `LKV_ASSERT_NEXT(a_result_follows, busy, out_valid && !busy, "result strobe missing")
  `LKV_ASSERT_SAME(a_evict_on_miss, out_valid && out_evicted, !out_hit,
                   "eviction reported on a hit")

endmodule

`default_nettype wire

// File: verif/lru_key_value_cache_top_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the LRU key-value cache.
// A shadow copy of the store (a recency queue, front = most recent) predicts
// hit / value / eviction for every accepted word; each result strobe is then
// compared against the oldest prediction.
module lru_key_value_cache_top_tb;
  import lkv_pkg::*;

  localparam int STORE_DEPTH  = 16;
  localparam int TARGET_WORDS = 1900;

  // One predicted result word.
  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] value_out;
    logic               evicted;
  } reply_t;

  // Shadow of the store plus the queue of replies still awaited.
  class cache_mirror;
    typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] val;
    } slot_t;

    slot_t            recency[$];   // index 0 is the most recent entry
    logic [CAP_W-1:0] capacity = CAP_RESET;
    reply_t           awaited[$];
    int unsigned      errors;

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    // Apply one accepted word to the shadow and queue its expected reply.
    function void note_access(logic cmd, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] val);
      reply_t r;
      slot_t  s;
      int     pos;
      int     limit;
      r   = '0;
      pos = -1;
      foreach (recency[i])
        if (pos < 0 && recency[i].key == key) pos = i;
      r.hit = (pos >= 0);
      if (pos >= 0) begin
        s = recency[pos];
        if (cmd == CMD_GET) r.value_out = s.val;
        else s.val = val;
        recency.delete(pos);
        recency.push_front(s);
      end else if (cmd == CMD_PUT) begin
        // zero behaves as one, anything past the depth saturates
        limit = (capacity == 0) ? 1 : ((capacity > STORE_DEPTH) ? STORE_DEPTH : capacity);
        // a lowered capacity may drop several entries at once
        if (recency.size() >= limit) begin
          r.evicted = 1'b1;
          while (recency.size() > limit - 1) void'(recency.pop_back());
        end
        s.key = key;
        s.val = val;
        recency.push_front(s);
      end
      awaited.push_back(r);
    endfunction

    function void check_reply(logic hit, logic [VALUE_W-1:0] value_out, logic evicted);
      reply_t want;
      if (awaited.size() == 0) begin
        $error("result word strobed with nothing expected");
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (hit !== want.hit) begin
        $error("out_hit: expected %0d, actual %0d", want.hit, hit);
        errors++;
      end
      if (value_out !== want.value_out) begin
        $error("out_value_out: expected 0x%08h, actual 0x%08h", want.value_out, value_out);
        errors++;
      end
      if (evicted !== want.evicted) begin
        $error("out_evicted: expected %0d, actual %0d", want.evicted, evicted);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic                     in_cmd;
  logic signed [KEY_W-1:0]  in_key;
  logic [VALUE_W-1:0]       in_value;
  logic                     out_valid;
  logic                     out_hit;
  logic [VALUE_W-1:0]       out_value_out;
  logic                     out_evicted;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CAP_W-1:0]         cfg_capacity_in_use;

  cache_mirror mirror;
  int          words_sent;

  lru_key_value_cache_top #(
    .ENTRIES(STORE_DEPTH)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_cmd              (in_cmd),
    .in_key              (in_key),
    .in_value            (in_value),
    .out_valid           (out_valid),
    .out_hit             (out_hit),
    .out_value_out       (out_value_out),
    .out_evicted         (out_evicted),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_capacity_in_use (cfg_capacity_in_use)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous cap on run time; a clean run needs well under a millisecond.
  initial begin
    #5_000_000;
    $display("lru_key_value_cache_top verification failed");
    $finish;
  end

  // Monitor: everything is sampled on the rising edge, before the DUT's own
  // updates land. The reply is checked before the new word is noted, since a
  // strobe can never belong to a word accepted on the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) mirror.check_reply(out_hit, out_value_out, out_evicted);
      if (start && !busy) mirror.note_access(in_cmd, in_key, in_value);
      if (cfg_valid && cfg_ready) mirror.set_capacity(cfg_capacity_in_use);
    end
  end

  // Mostly back-to-back, some short pauses, the odd long one.
  function automatic int pick_gap(bit idle_on);
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one word and hold it until accepted. With no gap, start simply
  // stays high for the next word.
  task automatic send_word(input logic cmd, input logic [KEY_W-1:0] key,
                           input logic [VALUE_W-1:0] val, input int gap);
    start    <= 1'b1;
    in_cmd   <= cmd;
    in_key   <= key;
    in_value <= val;
    do @(posedge clk); while (busy);
    words_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop issuing and wait until every reply is in, plus a short settle.
  task automatic drain_replies();
    int guard;
    guard = 0;
    start <= 1'b0;
    do begin
      @(posedge clk);
      guard++;
    end while (mirror.outstanding() != 0 && guard < 500);
    repeat (4) @(posedge clk);
  endtask

  // Capacity write; only ever called with the block idle.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_valid           <= 1'b1;
    cfg_capacity_in_use <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [KEY_W-1:0]   key_pool[$];
    logic [KEY_W-1:0]   key;
    logic [CAP_W-1:0]   cap;
    logic [CAP_W-1:0]   cap_plan[6];
    int                 eff_cap;
    int                 phase;
    int                 phase_words;
    int                 pool_size;
    bit                 idle_on;

    mirror     = new;
    words_sent = 0;
    cap_plan   = '{5'd31, 5'd16, 5'd1, 5'd0, 5'd17, 5'd8};

    rst_n               <= 1'b0;
    start               <= 1'b0;
    in_cmd              <= CMD_GET;
    in_key              <= '0;
    in_value            <= '0;
    cfg_valid           <= 1'b0;
    cfg_capacity_in_use <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed: reset capacity of 16 ---
    send_word(CMD_GET, 32'h0000_0000, '1, 0);             // miss on an empty store
    send_word(CMD_PUT, 32'h8000_0000, 31'h7FFF_FFFF, 0);  // most negative key, top value
    send_word(CMD_PUT, 32'h7FFF_FFFF, 31'h0, 1);          // most positive key, zero value
    send_word(CMD_PUT, 32'hFFFF_FFFF, 31'h5555_5555, 0);
    send_word(CMD_PUT, 32'h0000_0000, 31'h2AAA_AAAA, 2);
    send_word(CMD_GET, 32'h8000_0000, '0, 0);             // hit, refreshes recency
    send_word(CMD_PUT, 32'h7FFF_FFFF, 31'h1234_5678, 0);  // overwrite, entry moves to the front
    send_word(CMD_GET, 32'h7FFF_FFFF, '0, 0);
    // fill past the depth: the last put evicts the stalest entry (key -1)
    for (int i = 0; i < 13; i++)
      send_word(CMD_PUT, 32'(100 + i), 31'(i * 7), 0);
    send_word(CMD_GET, 32'hFFFF_FFFF, '0, 0);             // evicted, so a miss

    // capacity dropped below occupancy: next new key trims to two, then inserts
    drain_replies();
    write_capacity(5'd3);
    send_word(CMD_GET, 32'h0000_0000, '0, 0);
    send_word(CMD_PUT, 32'd200, 31'd1, 0);

    // capacity zero acts as one
    drain_replies();
    write_capacity(5'd0);
    send_word(CMD_PUT, 32'd201, 31'd2, 0);
    send_word(CMD_PUT, 32'd202, 31'd3, 0);
    send_word(CMD_GET, 32'd202, '0, 0);

    // --- random phases, each with its own capacity and key pool ---
    phase = 0;
    while (words_sent < TARGET_WORDS) begin
      cap     = (phase < 6) ? cap_plan[phase] : CAP_W'($urandom_range(0, 31));
      eff_cap = (cap == 0) ? 1 : ((cap > STORE_DEPTH) ? STORE_DEPTH : int'(cap));
      drain_replies();
      write_capacity(cap);

      // a pool a little larger than the capacity gives a healthy hit/evict mix
      pool_size = eff_cap + $urandom_range(1, eff_cap + 2);
      key_pool.delete();
      for (int i = 0; i < pool_size; i++) key_pool.push_back($urandom);
      if ($urandom_range(0, 1)) key_pool[0] = 32'h8000_0000;
      if ($urandom_range(0, 1)) key_pool[pool_size - 1] = 32'h7FFF_FFFF;

      idle_on     = ($urandom_range(0, 3) != 0);   // some phases run flat out
      phase_words = $urandom_range(100, 250);
      // the last phase stops at the word target
      if (phase_words > TARGET_WORDS - words_sent) phase_words = TARGET_WORDS - words_sent;
      for (int n = 0; n < phase_words; n++) begin
        // one word in ten uses a stray key
        if ($urandom_range(0, 9) == 0) key = $urandom;
        else key = key_pool[$urandom_range(0, pool_size - 1)];
        send_word(logic'($urandom_range(0, 1)), key, VALUE_W'($urandom), pick_gap(idle_on));
      end
      phase++;
    end

    drain_replies();
    if (mirror.errors == 0 && mirror.outstanding() == 0) begin
      $display("lru_key_value_cache_top verification clean");
    end else begin
      $display("lru_key_value_cache_top verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/lkv_pkg.sv
rtl/core/lkv_cell.sv
rtl/core/lru_key_value_cache_top.sv
verif/lru_key_value_cache_top_tb.sv
